// File: hw/rtl/gbn_pkg.sv
// Shared types and codes for the Go-Back-N sender window.
// Used by gbn_ctrl, gbn_datapath and go_back_n_sender_window_top; depends on nothing.
package gbn_pkg;

    // Field widths fixed by the port list.
    localparam int REQ_W      = 2;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int SEQ_PORT_W = 8;
    localparam int BYTE_W     = 8;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_DATA    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RX      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

    // Received frame kinds.
    localparam logic [BYTE_W-1:0] RX_ACK  = 8'd0;
    localparam logic [BYTE_W-1:0] RX_DATA = 8'd1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACK        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STALE      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BEYOND     = 3'd6;

    // Loss injection period after reset.
    localparam logic [BYTE_W-1:0] DROP_RESET = 8'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;
        logic                start_fill;
        logic                walk_step;
        logic                ack_start;
        logic                ack_step;
        logic                ack_finish;
        logic                emit_status;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             waiting;
        logic             kind_ack;
        logic             kind_data;
        logic             ack_ok;
        logic             ack_stale;
        logic             walk_emit;
        logic             walk_last;
        logic             ack_last;
        logic             out_free;
    } t_dp_stat;

endpackage

// File: hw/rtl/gbn_ctrl.sv
// Controller state machine of the Go-Back-N sender window.
// Depends on gbn_pkg; drives gbn_datapath through command and status structs.
module gbn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gbn_pkg::t_dp_stat i_stat,
    output gbn_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_ACK,
        S_ACK_END
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    assign o_ready = r_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.req_type == gbn_pkg::REQ_DATA && !i_stat.waiting) begin
                    n_state = S_WALK;
                end else if (i_stat.req_type == gbn_pkg::REQ_TIMEOUT && i_stat.waiting) begin
                    o_cmd.start_fill = 1'b1;
                    n_state          = S_WALK;
                end else if (i_stat.req_type == gbn_pkg::REQ_RX && i_stat.waiting
                             && i_stat.kind_ack && i_stat.ack_ok) begin
                    o_cmd.ack_start = 1'b1;
                    n_state         = S_ACK;
                end else if (i_stat.out_free) begin
                    // Every other request is answered by a single status result.
                    o_cmd.emit_status = 1'b1;
                    n_state           = S_IDLE;
                    if (i_stat.req_type != gbn_pkg::REQ_RX || !i_stat.waiting) begin
                        o_cmd.status = gbn_pkg::ST_BUSY;
                    end else if (i_stat.kind_ack) begin
                        o_cmd.status = i_stat.ack_stale ? gbn_pkg::ST_STALE
                                                        : gbn_pkg::ST_BEYOND;
                    end else if (i_stat.kind_data) begin
                        o_cmd.status = gbn_pkg::ST_UNEXPECTED;
                    end else begin
                        o_cmd.status = gbn_pkg::ST_INVALID;
                    end
                end
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    if (i_stat.walk_emit) begin
                        o_cmd.walk_step = 1'b1;
                        if (i_stat.walk_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        // Nothing to send in this walk.
                        o_cmd.emit_status = 1'b1;
                        o_cmd.status      = gbn_pkg::ST_OK;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_ACK: begin
                o_cmd.ack_step = 1'b1;
                if (i_stat.ack_last) begin
                    n_state = S_ACK_END;
                end
            end
            S_ACK_END: begin
                if (i_stat.out_free) begin
                    o_cmd.ack_finish  = 1'b1;
                    o_cmd.emit_status = 1'b1;
                    o_cmd.status      = gbn_pkg::ST_ACK;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    // State and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

endmodule

// File: hw/rtl/gbn_datapath.sv
// Datapath of the Go-Back-N sender window: window state, slot store, loss counter
// and output register. Depends on gbn_pkg; commanded by gbn_ctrl.
module gbn_datapath #(
    parameter int WINDOW    = 3,
    parameter int SEQ_BITS  = 8,
    parameter int DATA_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gbn_pkg::t_dp_cmd                i_cmd,
    output gbn_pkg::t_dp_stat               o_stat,
    input  logic [gbn_pkg::REQ_W-1:0]       i_req_type,
    input  logic [DATA_BITS-1:0]            i_payload,
    input  logic [gbn_pkg::BYTE_W-1:0]      i_rx_kind,
    input  logic [gbn_pkg::SEQ_PORT_W-1:0]  i_rx_seq,
    input  logic                            i_cfg_we,
    input  logic [gbn_pkg::BYTE_W-1:0]      i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [gbn_pkg::KIND_W-1:0]      o_out_kind,
    output logic [gbn_pkg::SEQ_PORT_W-1:0]  o_tx_seq,
    output logic [DATA_BITS-1:0]            o_tx_payload,
    output logic                            o_is_resend,
    output logic [gbn_pkg::STATUS_W-1:0]    o_status,
    output logic [gbn_pkg::SEQ_PORT_W-1:0]  o_base_now,
    output logic                            o_last
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int OFF_W  = $clog2(WINDOW + 1);
    localparam int EXT_W  = (SEQ_BITS > gbn_pkg::SEQ_PORT_W) ? SEQ_BITS : gbn_pkg::SEQ_PORT_W;

    // Window state.
    logic [SEQ_BITS-1:0]  r_base_seq;
    logic [SEQ_BITS-1:0]  r_round_base;
    logic [OFF_W-1:0]     r_fill_off;
    logic                 r_waiting;
    logic [SLOT_W-1:0]    r_fill_slot;
    logic [SLOT_W-1:0]    r_base_slot;
    logic [WINDOW-1:0]    r_held;
    logic [DATA_BITS-1:0] r_slot_data [WINDOW];
    logic [gbn_pkg::BYTE_W-1:0] r_drop_cnt;
    logic [gbn_pkg::BYTE_W-1:0] r_drop_period;

    // Request being worked on.
    logic [gbn_pkg::REQ_W-1:0]  r_req;
    logic [DATA_BITS-1:0]       r_data;
    logic [gbn_pkg::BYTE_W-1:0] r_rx_kind;
    logic [SEQ_BITS-1:0]        r_rx_seq;
    logic                       r_have;
    logic [SLOT_W-1:0]          r_ack_left;
    logic                       r_ack_full;

    // Output register.
    logic                             r_out_valid;
    logic [gbn_pkg::KIND_W-1:0]       r_out_kind;
    logic [gbn_pkg::SEQ_PORT_W-1:0]   r_tx_seq;
    logic [DATA_BITS-1:0]             r_tx_payload;
    logic                             r_is_resend;
    logic [gbn_pkg::STATUS_W-1:0]     r_status;
    logic [gbn_pkg::SEQ_PORT_W-1:0]   r_base_now;
    logic                             r_last;

    logic [EXT_W-1:0]    rx_ext;
    logic [SEQ_BITS-1:0] outstanding;
    logic [SEQ_BITS-1:0] ack_dist;
    logic                ack_ok;
    logic                ack_full;
    logic                cur_held;
    logic [SLOT_W-1:0]   nxt_slot;
    logic [OFF_W-1:0]    nxt_off;
    logic                walk_emit;
    logic                walk_last;
    logic [gbn_pkg::BYTE_W:0] cnt_next;
    logic                drop_now;
    logic                out_free;
    logic                out_load;
    logic                fill_restart;
    logic [SEQ_BITS-1:0] tx_seq_full;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(WINDOW - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [gbn_pkg::SEQ_PORT_W-1:0] seq_port(input logic [SEQ_BITS-1:0] s);
        logic [EXT_W-1:0] e;
        e = EXT_W'(s);
        return e[gbn_pkg::SEQ_PORT_W-1:0];
    endfunction

    // Ack classification against the frames sent in this round.
    assign rx_ext      = EXT_W'(i_rx_seq);
    assign outstanding = r_round_base + SEQ_BITS'(WINDOW) - r_base_seq;
    assign ack_dist    = r_rx_seq - r_base_seq;
    assign ack_ok      = ack_dist < outstanding;
    assign ack_full    = ({1'b0, ack_dist} + (SEQ_BITS + 1)'(1)) >= {1'b0, outstanding};

    // Fill walk: current position and a look ahead at the next one.
    assign cur_held    = r_held[r_fill_slot];
    assign nxt_slot    = slot_inc(r_fill_slot);
    assign nxt_off     = r_fill_off + OFF_W'(1);
    assign walk_emit   = (r_fill_off < OFF_W'(WINDOW)) && (cur_held || r_have);
    assign walk_last   = (nxt_off >= OFF_W'(WINDOW))
                         || !(r_held[nxt_slot] || (r_have && cur_held));
    assign tx_seq_full = r_round_base + SEQ_BITS'(r_fill_off);

    // Loss injection.
    assign cnt_next = {1'b0, r_drop_cnt} + (gbn_pkg::BYTE_W + 1)'(1);
    assign drop_now = (r_drop_period != '0) && (cnt_next >= {1'b0, r_drop_period});

    assign out_free     = !r_out_valid || i_ready;
    assign out_load     = i_cmd.walk_step || i_cmd.emit_status;
    assign fill_restart = i_cmd.start_fill || (i_cmd.ack_finish && r_ack_full);

    // Status to the controller.
    always_comb begin
        o_stat.req_type  = r_req;
        o_stat.waiting   = r_waiting;
        o_stat.kind_ack  = (r_rx_kind == gbn_pkg::RX_ACK);
        o_stat.kind_data = (r_rx_kind == gbn_pkg::RX_DATA);
        o_stat.ack_ok    = ack_ok;
        o_stat.ack_stale = ack_dist[SEQ_BITS-1];
        o_stat.walk_emit = walk_emit;
        o_stat.walk_last = walk_last;
        o_stat.ack_last  = (r_ack_left == '0);
        o_stat.out_free  = out_free;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_seq    <= '0;
            r_round_base  <= '0;
            r_fill_off    <= '0;
            r_waiting     <= 1'b0;
            r_fill_slot   <= '0;
            r_base_slot   <= '0;
            r_held        <= '0;
            r_drop_cnt    <= '0;
            r_drop_period <= gbn_pkg::DROP_RESET;
            r_have        <= 1'b0;
            r_ack_left    <= '0;
            r_ack_full    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_drop_period <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_have <= (i_req_type == gbn_pkg::REQ_DATA);
            end
            if (fill_restart) begin
                r_waiting    <= 1'b0;
                r_round_base <= r_base_seq;
                r_fill_off   <= '0;
                r_fill_slot  <= r_base_slot;
            end
            if (i_cmd.walk_step) begin
                if (r_drop_period != '0) begin
                    r_drop_cnt <= drop_now ? '0 : cnt_next[gbn_pkg::BYTE_W-1:0];
                end
                if (!cur_held) begin
                    r_held[r_fill_slot] <= 1'b1;
                    r_have              <= 1'b0;
                end
                r_fill_off  <= nxt_off;
                r_fill_slot <= nxt_slot;
                if (nxt_off >= OFF_W'(WINDOW)) begin
                    r_waiting <= 1'b1;
                end
            end
            if (i_cmd.ack_start) begin
                r_ack_left <= ack_dist[SLOT_W-1:0];
                r_ack_full <= ack_full;
            end
            // Release one slot at base per cycle.
            if (i_cmd.ack_step) begin
                r_held[r_base_slot] <= 1'b0;
                r_base_slot         <= slot_inc(r_base_slot);
                r_base_seq          <= r_base_seq + SEQ_BITS'(1);
                r_ack_left          <= r_ack_left - SLOT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, slot store and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req     <= i_req_type;
            r_data    <= i_payload;
            r_rx_kind <= i_rx_kind;
            r_rx_seq  <= rx_ext[SEQ_BITS-1:0];
        end
        if (i_cmd.walk_step && !cur_held) begin
            r_slot_data[r_fill_slot] <= r_data;
        end
        if (i_cmd.walk_step) begin
            r_out_kind   <= drop_now ? gbn_pkg::KIND_DROPPED : gbn_pkg::KIND_SENT;
            r_tx_seq     <= seq_port(tx_seq_full);
            r_tx_payload <= cur_held ? r_slot_data[r_fill_slot] : r_data;
            r_is_resend  <= cur_held;
            r_status     <= gbn_pkg::ST_OK;
            r_base_now   <= seq_port(r_base_seq);
            r_last       <= walk_last;
        end else if (i_cmd.emit_status) begin
            r_out_kind   <= gbn_pkg::KIND_STATUS;
            r_tx_seq     <= '0;
            r_tx_payload <= '0;
            r_is_resend  <= 1'b0;
            r_status     <= i_cmd.status;
            r_base_now   <= seq_port(r_base_seq);
            r_last       <= 1'b1;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_tx_seq     = r_tx_seq;
    assign o_tx_payload = r_tx_payload;
    assign o_is_resend  = r_is_resend;
    assign o_status     = r_status;
    assign o_base_now   = r_base_now;
    assign o_last       = r_last;

    // The fill offset never passes the window.
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_off <= OFF_W'(WINDOW))
        else $error("fill offset beyond window");

    // The wait phase is exactly the state of a fully walked window.
    a_wait_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting == (r_fill_off == OFF_W'(WINDOW)))
        else $error("wait phase and fill offset disagree");

    // A result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output register overwritten");

    // An accepted ack only releases slots that are held.
    a_ack_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ack_step |-> r_held[r_base_slot])
        else $error("ack released an empty slot");

    // After the final frame of a walk nothing more is left to send.
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk_step && walk_last) |=> !walk_emit)
        else $error("walk ended with frames still due");

endmodule

// File: hw/rtl/go_back_n_sender_window_top.sv
// Go-Back-N sender window: a request is taken, then a dispatch cycle decides its work.
// Status-only results are loaded from the dispatch state; a fill or timeout walk emits
// one frame per cycle, up to WINDOW frames, paced by the output register.
// An accepted ack at distance d from base releases d+1 slots (one slot a cycle), then its status.
// The next request is taken on the cycle after the final result is loaded.
// Reset is synchronous, active low: window cleared, fill phase, loss period 5, no sweep.
module go_back_n_sender_window_top #(
    parameter int WINDOW    = 3,
    parameter int SEQ_BITS  = 8,
    parameter int DATA_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [gbn_pkg::REQ_W-1:0]       i_req_type,
    input  logic [DATA_BITS-1:0]            i_payload,
    input  logic [gbn_pkg::BYTE_W-1:0]      i_rx_kind,
    input  logic [gbn_pkg::SEQ_PORT_W-1:0]  i_rx_seq,
    input  logic                            i_cfg_we,
    input  logic [gbn_pkg::BYTE_W-1:0]      i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [gbn_pkg::KIND_W-1:0]      o_out_kind,
    output logic [gbn_pkg::SEQ_PORT_W-1:0]  o_tx_seq,
    output logic [DATA_BITS-1:0]            o_tx_payload,
    output logic                            o_is_resend,
    output logic [gbn_pkg::STATUS_W-1:0]    o_status,
    output logic [gbn_pkg::SEQ_PORT_W-1:0]  o_base_now,
    output logic                            o_last
);

    gbn_pkg::t_dp_cmd  dp_cmd;
    gbn_pkg::t_dp_stat dp_stat;

    // Sequencing of each request.
    gbn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Window state and result generation.
    gbn_datapath #(
        .WINDOW    (WINDOW),
        .SEQ_BITS  (SEQ_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_req_type   (i_req_type),
        .i_payload    (i_payload),
        .i_rx_kind    (i_rx_kind),
        .i_rx_seq     (i_rx_seq),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_kind   (o_out_kind),
        .o_tx_seq     (o_tx_seq),
        .o_tx_payload (o_tx_payload),
        .o_is_resend  (o_is_resend),
        .o_status     (o_status),
        .o_base_now   (o_base_now),
        .o_last       (o_last)
    );

endmodule
